FILE: rtl/lkvc_pkg.sv
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

  localparam int unsigned KEY_PORT_BITS    = 32;
  localparam int unsigned DATA_BITS        = 32;
  localparam int unsigned CAP_BITS         = 5;
  localparam int unsigned DEPTH_DEFAULT    = 16;
  localparam int unsigned KEY_BITS_DEFAULT = 32;

  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_STORE  = 1'b1
  } lkvc_cmd_e;

  typedef struct packed {
    lkvc_cmd_e                     cmd;
    logic [KEY_PORT_BITS-1:0]      key;
    logic signed [DATA_BITS-1:0]   data_in;
  } lkvc_req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [DATA_BITS-1:0]   data_out;
    logic                          evicted;
  } lkvc_rsp_t;

endpackage

FILE: rtl/lru_key_value_cache_core.sv
// Top level of the fully associative key/value cache with LRU replacement.
//
// Usage: an item (lookup or store command, key and value) is taken at a
// rising edge where start is high and busy is low. busy never rises, so one
// item may be given in every cycle. The item is captured in an input register,
// the compare over all entries and the recency update run in the following
// cycle, and the result is registered with the state update. valid_o is then
// high for exactly one cycle with the result on rsp_o. Throughput is one item
// per cycle, with a parallel key compare and a one-hot value mux across all
// entries. The receiver cannot stall; a result is shown once and is gone at
// the next edge.
// The capacity register is written via cfg_we_i/cfg_capacity_i; the user must
// write it only while no item is in flight (the block does not enforce it).
// Zero acts as one, values above DEPTH as DEPTH. Reset empties the cache at
// once (fill count, ranks to zero), sets capacity to sixteen; no clearing pass.
module lru_key_value_cache_core #(
  parameter int unsigned DEPTH    = lkvc_pkg::DEPTH_DEFAULT,
  parameter int unsigned KEY_BITS = lkvc_pkg::KEY_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  lkvc_pkg::lkvc_req_t               req_i,
  input  logic                              cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0]     cfg_capacity_i,
  output logic                              valid_o,
  output lkvc_pkg::lkvc_rsp_t               rsp_o
);

  import lkvc_pkg::*;

  // Keys beyond the port width cannot occur, so storage is the smaller width.
  localparam int unsigned KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = $clog2(DEPTH);
  localparam int unsigned EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CAP_BITS-1:0]  capacity_q;
  logic                 in_valid_q;
  lkvc_req_t            in_q;
  logic                 valid_q;
  lkvc_rsp_t            rsp_q, rsp_d;
  logic [CW-1:0]        count_q, count_d;
  logic [KW-1:0]        keys_q [DEPTH];
  logic [DATA_BITS-1:0] values_q [DEPTH];
  logic [RW-1:0]        ranks_q [DEPTH];
  logic [RW-1:0]        ranks_d [DEPTH];

  logic [KW-1:0]        key;
  logic [DEPTH-1:0]     valid, match_oh, victim_oh, slot_oh, touch_oh;
  logic [EW-1:0]        cap_ext, eff_cap;
  logic                 is_store, hit, evict, insert, key_we, value_we;
  logic [RW-1:0]        hit_rank;
  logic [DATA_BITS-1:0] hit_value;

  assign busy = 1'b0;
  assign key  = in_q.key[KW-1:0];

  lkvc_match #(
    .DEPTH(DEPTH),
    .KW   (KW),
    .CW   (CW),
    .RW   (RW)
  ) u_match (
    .key_i      (key),
    .keys_i     (keys_q),
    .ranks_i    (ranks_q),
    .count_i    (count_q),
    .valid_o    (valid),
    .match_oh_o (match_oh),
    .victim_oh_o(victim_oh),
    .slot_oh_o  (slot_oh)
  );

  // Effective capacity, clamped to the range one to DEPTH.
  always_comb begin
    cap_ext = EW'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Stored keys are unique, so at most one entry matches and the one-hot
  // vectors can be folded with plain OR trees.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_oh[i]) begin
        hit_rank  = hit_rank | ranks_q[i];
        hit_value = hit_value | values_q[i];
      end
    end
  end

  always_comb begin
    is_store = in_valid_q && (in_q.cmd == CMD_STORE);
    hit      = in_valid_q && (|match_oh);
    // A store miss on a full cache recycles the least recent entry; otherwise the
    // key goes into the next free entry at the fill count.
    evict    = is_store && !hit && (EW'(count_q) >= eff_cap);
    insert   = is_store && !hit && !evict;

    if (hit) begin
      touch_oh = match_oh;
    end else if (evict) begin
      touch_oh = victim_oh;
    end else if (insert) begin
      touch_oh = slot_oh;
    end else begin
      touch_oh = '0;
    end
    key_we   = is_store && !hit;
    value_we = is_store;

    // The touched entry becomes the most recent. Every valid entry that was
    // more recent than it ages by one; for an eviction or an insertion that is
    // every other valid entry.
    for (int i = 0; i < DEPTH; i++) begin
      ranks_d[i] = ranks_q[i];
      if (touch_oh[i]) begin
        ranks_d[i] = '0;
      end else if (valid[i] && (evict || insert || (hit && (ranks_q[i] < hit_rank)))) begin
        ranks_d[i] = ranks_q[i] + RW'(1);
      end
    end

    count_d = insert ? count_q + CW'(1) : count_q;

    rsp_d.hit      = hit;
    rsp_d.data_out = (hit && !is_store) ? hit_value : '0;
    rsp_d.evicted  = evict;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      in_valid_q <= 1'b0;
      valid_q    <= 1'b0;
      count_q    <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        ranks_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_capacity_i;
      end
      in_valid_q <= start && !busy;
      valid_q    <= in_valid_q;
      count_q    <= count_d;
      ranks_q    <= ranks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
    if (in_valid_q) begin
      rsp_q <= rsp_d;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (key_we && touch_oh[i]) begin
        keys_q[i] <= key;
      end
      if (value_we && touch_oh[i]) begin
        values_q[i] <= in_q.data_in;
      end
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: rtl/lkvc_match.sv
// Parallel key compare and one-hot entry selection of the LRU key/value cache.
module lkvc_match #(
  parameter int unsigned DEPTH = lkvc_pkg::DEPTH_DEFAULT,
  parameter int unsigned KW    = lkvc_pkg::KEY_BITS_DEFAULT,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter int unsigned RW    = $clog2(DEPTH)
) (
  input  logic [KW-1:0]    key_i,
  input  logic [KW-1:0]    keys_i [DEPTH],
  input  logic [RW-1:0]    ranks_i [DEPTH],
  input  logic [CW-1:0]    count_i,
  output logic [DEPTH-1:0] valid_o,
  output logic [DEPTH-1:0] match_oh_o,
  output logic [DEPTH-1:0] victim_oh_o,
  output logic [DEPTH-1:0] slot_oh_o
);

  logic [RW-1:0] oldest_rank;

  // Entries are filled from the bottom and never freed, so the valid ones are
  // exactly those below the fill count and the next free one sits at the count.
  // Valid ranks are distinct and run from zero to count minus one.
  assign oldest_rank = RW'(count_i - CW'(1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_o[i]     = CW'(i) < count_i;
      slot_oh_o[i]   = CW'(i) == count_i;
      match_oh_o[i]  = valid_o[i] && (keys_i[i] == key_i);
      victim_oh_o[i] = valid_o[i] && (ranks_i[i] == oldest_rank);
    end
  end

endmodule
